// ===== rtl/cpds_pkg.sv =====
// Shared types and constants for the class pairwise distance sum block.
`default_nettype none

package cpds_pkg;

  // Storage sizes
  localparam int unsigned MAX_CELLS    = 4096;
  localparam int unsigned MAX_CLASSES  = 8;
  localparam int unsigned MAX_EXISTING = 1024;
  localparam int unsigned CELL_AW      = $clog2(MAX_CELLS);
  localparam int unsigned EX_AW        = $clog2(MAX_EXISTING);

  // Field widths
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned TOT_W   = 40;
  localparam int unsigned ROOT_W  = 20;
  localparam int unsigned RAD_W   = 2 * ROOT_W;
  localparam int unsigned EX_CW   = 3;
  localparam int unsigned EX_W    = EX_CW + IDX_W;
  localparam int unsigned DIM_W   = 7;

  // Square root unit: one result bit per cycle
  localparam int unsigned SQRT_STEPS = ROOT_W;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CLASS  = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_I_RD,
    ST_I_WT,
    ST_J_RD,
    ST_J_WT,
    ST_SQ1,
    ST_SQ2,
    ST_SQS,
    ST_SQW,
    ST_E_RD,
    ST_E_WT,
    ST_DIV,
    ST_DONE
  } state_e;

  // Status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cpds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cpds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/cpds_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
`default_nettype none

module cpds_sqrt (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [cpds_pkg::RAD_W-1:0]     radicand_i,
  output cpds_pkg::sqrt_stat_t                stat_o,
  output logic      [cpds_pkg::ROOT_W-1:0]    root_o
);

  localparam int unsigned REM_W = cpds_pkg::ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(cpds_pkg::SQRT_STEPS);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [cpds_pkg::RAD_W-1:0]    rad_q, rad_d;
  logic [REM_W-1:0]              rem_q, rem_d;
  logic [cpds_pkg::ROOT_W-1:0]   root_q, root_d;

  logic [REM_W-1:0]              rem_sh;
  logic [REM_W-1:0]              trial;
  logic                          ge;

  // One digit step: bring down two radicand bits and try root*4+1
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[cpds_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[cpds_pkg::ROOT_W-2:0], ge};
      rad_d  = {rad_q[cpds_pkg::RAD_W-3:0], 2'b00};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(cpds_pkg::SQRT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

// ===== rtl/class_pairwise_distance_sum.sv =====
// Top level: command intake, plan and tile stores, pair-walking sequencer.
//
//  Channel     Direction  Handshake                     Payload
//  s_axis      in         s_axis_tvalid/s_axis_tready   cmd, cell_index, class_code
//  m_axis      out        m_axis_tvalid/m_axis_tready   status, total_distance
//  cfg         in         cfg_valid_i/cfg_ready_o       cfg_addr_i, cfg_data_i
//
// Load, add and clear give their result on m_axis in the cycle after they are accepted.
// Compute walks every same-class cell pair and every tile-cell pair: it reads the
// plan, splits each tile index into row and column with the divider, and sends
// each matching pair through the shared multiplier and the one-bit-a-cycle square root.
// s_axis_tready is low for the whole compute and while a result waits on m_axis.
// Reset is asynchronous and active low; the stores are not cleared.
`default_nettype none

module class_pairwise_distance_sum (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [1:0] cmd, [13:2] cell_index, [17:14] class_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // [1:0] status, [41:2] total_distance
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [6:0]  cfg_data_i
);

  localparam int unsigned CNT_W  = cpds_pkg::CELL_AW + 1;
  localparam int unsigned EXC_W  = cpds_pkg::EX_AW + 1;
  localparam int unsigned RROW_W = cpds_pkg::IDX_W;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned D2_W   = 2 * RROW_W;
  localparam int unsigned DCNT_W = $clog2(cpds_pkg::IDX_W);

  // Input fields
  cpds_pkg::cmd_e                  in_cmd;
  logic [cpds_pkg::IDX_W-1:0]      in_idx;
  logic [cpds_pkg::CODE_W-1:0]     in_code;
  logic                            in_fire;

  assign in_cmd  = cpds_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_idx  = s_axis_tdata[13:2];
  assign in_code = s_axis_tdata[17:14];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  logic [cpds_pkg::DIM_W-1:0] gw_q, gh_q;
  logic [3:0]                 cc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= 7'd64;
      gh_q <= 7'd64;
      cc_q <= 4'd8;
    end else if (cfg_valid_i) begin
      unique case (cpds_pkg::reg_e'(cfg_addr_i))
        cpds_pkg::REG_WIDTH:  gw_q <= cfg_data_i;
        cpds_pkg::REG_HEIGHT: gh_q <= cfg_data_i;
        cpds_pkg::REG_CLASS:  cc_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective grid and class count
  logic [cpds_pkg::DIM_W-1:0]   w_eff, h_eff;
  logic [2*cpds_pkg::DIM_W-1:0] cells_full;
  logic [CNT_W-1:0]             cells;
  logic [3:0]                   nh;

  assign w_eff = (gw_q == '0) ? 7'd1 : ((gw_q > 7'd64) ? 7'd64 : gw_q);
  assign h_eff = (gh_q == '0) ? 7'd1 : ((gh_q > 7'd64) ? 7'd64 : gh_q);
  assign cells_full = w_eff * h_eff;
  assign cells = CNT_W'(cells_full);
  assign nh = (cc_q > 4'(cpds_pkg::MAX_CLASSES)) ? 4'(cpds_pkg::MAX_CLASSES) : cc_q;

  // Sequencer state
  cpds_pkg::state_e state_q, state_d;
  logic             phase_q, phase_d;   // 0: plan pairs, 1: tile-cell pairs
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
  logic [ROW_W-1:0] ri_q, ri_d, rj_q, rj_d;
  logic [COL_W-1:0] ci_q, ci_d, cj_q, cj_d;
  logic [RROW_W-1:0] rr_q, rr_d;
  logic [COL_W-1:0] rc_q, rc_d;
  logic [3:0]       cls_q, cls_d;
  logic [EXC_W-1:0] e_q, e_d, exc_q, exc_d;
  logic [cpds_pkg::TOT_W-1:0] total_q, total_d;
  logic [D2_W-1:0]  d2_q, d2_d;
  logic [cpds_pkg::IDX_W-1:0] dsh_q, dsh_d;
  logic [COL_W-1:0] drem_q, drem_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;

  // Output register
  logic                       ov_q, ov_d;
  logic [1:0]                 ost_q, ost_d;
  logic [cpds_pkg::TOT_W-1:0] otot_q, otot_d;
  logic                       slot_free;

  assign slot_free = !ov_q || m_axis_tready;

  // Stores
  logic                          plan_we, ex_we;
  logic [cpds_pkg::CELL_AW-1:0]  plan_raddr;
  logic [cpds_pkg::CODE_W-1:0]   plan_rdata;
  logic [cpds_pkg::EX_W-1:0]     ex_rdata;

  cpds_ram #(
    .WIDTH (cpds_pkg::CODE_W),
    .DEPTH (cpds_pkg::MAX_CELLS)
  ) u_plan_ram (
    .clk_i   (clk_i),
    .we_i    (plan_we),
    .waddr_i (in_idx[cpds_pkg::CELL_AW-1:0]),
    .wdata_i (in_code),
    .raddr_i (plan_raddr),
    .rdata_o (plan_rdata)
  );

  cpds_ram #(
    .WIDTH (cpds_pkg::EX_W),
    .DEPTH (cpds_pkg::MAX_EXISTING)
  ) u_ex_ram (
    .clk_i   (clk_i),
    .we_i    (ex_we),
    .waddr_i (exc_q[cpds_pkg::EX_AW-1:0]),
    .wdata_i ({in_code[cpds_pkg::EX_CW-1:0], in_idx}),
    .raddr_i (e_q[cpds_pkg::EX_AW-1:0]),
    .rdata_o (ex_rdata)
  );

  // Shared square root unit
  logic                         sq_start;
  cpds_pkg::sqrt_stat_t         sq_stat;
  logic [cpds_pkg::ROOT_W-1:0]  sq_root;

  cpds_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({d2_q, 16'h0000}),
    .stat_o     (sq_stat),
    .root_o     (sq_root)
  );

  // Shared squarer and absolute differences
  logic [RROW_W-1:0] dr;
  logic [COL_W-1:0]  dc;
  logic [RROW_W-1:0] mul_a;
  logic [D2_W-1:0]   prod;

  assign dr    = (rr_q > RROW_W'(rj_q)) ? (rr_q - RROW_W'(rj_q)) : (RROW_W'(rj_q) - rr_q);
  assign dc    = (rc_q > cj_q) ? (rc_q - cj_q) : (cj_q - rc_q);
  assign mul_a = (state_q == cpds_pkg::ST_SQ1) ? dr : RROW_W'(dc);
  assign prod  = mul_a * mul_a;

  // Saturating accumulate
  logic [cpds_pkg::TOT_W:0] sum_w;
  assign sum_w = {1'b0, total_q} + (cpds_pkg::TOT_W + 1)'(sq_root);

  // Restoring divider step for tile row/column
  logic [COL_W:0] dv_r;
  logic           dv_ge;
  logic [COL_W-1:0] dv_rem;
  logic [cpds_pkg::IDX_W-1:0] dv_sh;

  assign dv_r   = {drem_q, dsh_q[cpds_pkg::IDX_W-1]};
  assign dv_ge  = (dv_r >= w_eff);
  assign dv_rem = dv_ge ? COL_W'(dv_r - w_eff) : dv_r[COL_W-1:0];
  assign dv_sh  = {dsh_q[cpds_pkg::IDX_W-2:0], dv_ge};

  // Loop end flags and coordinate steps
  logic [CNT_W-1:0] i_nx, j_nx;
  logic [EXC_W-1:0] e_nx;
  logic             i_end, j_end, e_end;
  logic             ci_wrap, cj_wrap;

  assign i_nx    = i_q + CNT_W'(1);
  assign j_nx    = j_q + CNT_W'(1);
  assign e_nx    = e_q + EXC_W'(1);
  assign i_end   = (i_nx >= cells);
  assign j_end   = (j_nx >= cells);
  assign e_end   = (e_nx >= exc_q);
  assign ci_wrap = (7'(ci_q) + 7'd1 == w_eff);
  assign cj_wrap = (7'(cj_q) + 7'd1 == w_eff);

  // Ex tile fields
  logic [cpds_pkg::EX_CW-1:0] ex_cls;
  logic [cpds_pkg::IDX_W-1:0] ex_idx;
  assign ex_cls = ex_rdata[cpds_pkg::EX_W-1 -: cpds_pkg::EX_CW];
  assign ex_idx = ex_rdata[cpds_pkg::IDX_W-1:0];

  logic in_range;
  assign in_range = (CNT_W'(in_idx) < cells);

  // Next state and datapath control
  always_comb begin
    // Loop advance shared by the pair states
    logic go_next_i, go_next_e, go_next_j;

    state_d = state_q;
    phase_d = phase_q;
    i_d = i_q;  ri_d = ri_q;  ci_d = ci_q;
    j_d = j_q;  rj_d = rj_q;  cj_d = cj_q;
    rr_d = rr_q; rc_d = rc_q; cls_d = cls_q;
    e_d = e_q;  exc_d = exc_q;
    total_d = total_q;
    d2_d = d2_q;
    dsh_d = dsh_q; drem_d = drem_q; dcnt_d = dcnt_q;
    ov_d = ov_q && !m_axis_tready;
    ost_d = ost_q;
    otot_d = otot_q;
    plan_we = 1'b0;
    ex_we = 1'b0;
    sq_start = 1'b0;
    plan_raddr = i_q[cpds_pkg::CELL_AW-1:0];
    s_axis_tready = (state_q == cpds_pkg::ST_IDLE) && slot_free;

    go_next_i = 1'b0;
    go_next_e = 1'b0;
    go_next_j = 1'b0;

    unique case (state_q)
      cpds_pkg::ST_IDLE: begin
        if (in_fire) begin
          ost_d  = cpds_pkg::STAT_OK;
          otot_d = '0;
          unique case (in_cmd)
            cpds_pkg::CMD_LOAD: begin
              ov_d = 1'b1;
              if (!in_range) ost_d = cpds_pkg::STAT_RANGE;
              else plan_we = 1'b1;
            end
            cpds_pkg::CMD_ADD: begin
              ov_d = 1'b1;
              if (!in_range) begin
                ost_d = cpds_pkg::STAT_RANGE;
              end else if (exc_q >= EXC_W'(cpds_pkg::MAX_EXISTING)) begin
                ost_d = cpds_pkg::STAT_FULL;
              end else if (!in_code[cpds_pkg::CODE_W-1]) begin
                ex_we = 1'b1;
                exc_d = exc_q + EXC_W'(1);
              end
            end
            cpds_pkg::CMD_CLEAR: begin
              ov_d  = 1'b1;
              exc_d = '0;
            end
            cpds_pkg::CMD_COMPUTE: begin
              total_d = '0;
              phase_d = 1'b0;
              i_d = '0; ri_d = '0; ci_d = '0;
              state_d = cpds_pkg::ST_I_RD;
            end
            default: ;
          endcase
        end
      end
      cpds_pkg::ST_I_RD: begin
        plan_raddr = i_q[cpds_pkg::CELL_AW-1:0];
        state_d = cpds_pkg::ST_I_WT;
      end
      cpds_pkg::ST_I_WT: begin
        if (plan_rdata < nh && !i_end) begin
          cls_d = plan_rdata;
          rr_d  = RROW_W'(ri_q);
          rc_d  = ci_q;
          j_d   = i_nx;
          rj_d  = ci_wrap ? ri_q + ROW_W'(1) : ri_q;
          cj_d  = ci_wrap ? '0 : ci_q + COL_W'(1);
          state_d = cpds_pkg::ST_J_RD;
        end else begin
          go_next_i = 1'b1;
        end
      end
      cpds_pkg::ST_J_RD: begin
        plan_raddr = j_q[cpds_pkg::CELL_AW-1:0];
        state_d = cpds_pkg::ST_J_WT;
      end
      cpds_pkg::ST_J_WT: begin
        if (plan_rdata == cls_q) state_d = cpds_pkg::ST_SQ1;
        else go_next_j = 1'b1;
      end
      cpds_pkg::ST_SQ1: begin
        d2_d = prod;
        state_d = cpds_pkg::ST_SQ2;
      end
      cpds_pkg::ST_SQ2: begin
        d2_d = d2_q + prod;
        state_d = cpds_pkg::ST_SQS;
      end
      cpds_pkg::ST_SQS: begin
        sq_start = 1'b1;
        state_d = cpds_pkg::ST_SQW;
      end
      cpds_pkg::ST_SQW: begin
        if (sq_stat.done) begin
          total_d = sum_w[cpds_pkg::TOT_W] ? '1 : sum_w[cpds_pkg::TOT_W-1:0];
          go_next_j = 1'b1;
        end
      end
      cpds_pkg::ST_E_RD: begin
        state_d = cpds_pkg::ST_E_WT;
      end
      cpds_pkg::ST_E_WT: begin
        if (4'(ex_cls) < nh) begin
          cls_d  = 4'(ex_cls);
          dsh_d  = ex_idx;
          drem_d = '0;
          dcnt_d = '0;
          state_d = cpds_pkg::ST_DIV;
        end else begin
          go_next_e = 1'b1;
        end
      end
      cpds_pkg::ST_DIV: begin
        dsh_d  = dv_sh;
        drem_d = dv_rem;
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(cpds_pkg::IDX_W - 1)) begin
          rr_d = dv_sh;
          rc_d = dv_rem;
          j_d = '0; rj_d = '0; cj_d = '0;
          state_d = cpds_pkg::ST_J_RD;
        end
      end
      cpds_pkg::ST_DONE: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          ost_d  = cpds_pkg::STAT_OK;
          otot_d = total_q;
          state_d = cpds_pkg::ST_IDLE;
        end
      end
      default: state_d = cpds_pkg::ST_IDLE;
    endcase

    // Inner loop step, falling through to the outer loop of the phase
    if (go_next_j) begin
      if (!j_end) begin
        j_d  = j_nx;
        rj_d = cj_wrap ? rj_q + ROW_W'(1) : rj_q;
        cj_d = cj_wrap ? '0 : cj_q + COL_W'(1);
        state_d = cpds_pkg::ST_J_RD;
      end else if (!phase_q) begin
        go_next_i = 1'b1;
      end else begin
        go_next_e = 1'b1;
      end
    end

    if (go_next_i) begin
      if (!i_end) begin
        i_d  = i_nx;
        ri_d = ci_wrap ? ri_q + ROW_W'(1) : ri_q;
        ci_d = ci_wrap ? '0 : ci_q + COL_W'(1);
        state_d = cpds_pkg::ST_I_RD;
      end else if (exc_q == '0) begin
        state_d = cpds_pkg::ST_DONE;
      end else begin
        phase_d = 1'b1;
        e_d = '0;
        state_d = cpds_pkg::ST_E_RD;
      end
    end

    if (go_next_e) begin
      if (e_end) begin
        state_d = cpds_pkg::ST_DONE;
      end else begin
        e_d = e_nx;
        state_d = cpds_pkg::ST_E_RD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpds_pkg::ST_IDLE;
      phase_q <= 1'b0;
      exc_q   <= '0;
      ov_q    <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      exc_q   <= exc_d;
      ov_q    <= ov_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    i_q <= i_d;   ri_q <= ri_d;  ci_q <= ci_d;
    j_q <= j_d;   rj_q <= rj_d;  cj_q <= cj_d;
    rr_q <= rr_d; rc_q <= rc_d;  cls_q <= cls_d;
    e_q <= e_d;
    total_q <= total_d;
    d2_q <= d2_d;
    dsh_q <= dsh_d;
    drem_q <= drem_d;
    ost_q <= ost_d;
    otot_q <= otot_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'b000000, otot_q, ost_q};

  // Checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == cpds_pkg::ST_IDLE))
    else $error("intake open outside idle");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exc_q <= EXC_W'(cpds_pkg::MAX_EXISTING))
    else $error("existing count past capacity");

  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_stat.busy)
    else $error("square root started while busy");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_cmd != cpds_pkg::CMD_COMPUTE) |=> m_axis_tvalid)
    else $error("missing result after single-cycle command");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for class_pairwise_distance_sum: directed and random stimulus with a behavioral predictor.
`timescale 1ns / 1ps

module testbench;
  import cpds_pkg::*;

  localparam int unsigned RUN_LIMIT = 8000000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ITEM_TARGET = 1300;

  typedef struct {
    status_e     status;
    logic [39:0] total;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = '0;
  logic [6:0]  cfg_data_i = '0;

  class_pairwise_distance_sum dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [3:0]  plan_q [MAX_CELLS];
  bit          plan_set [MAX_CELLS];
  int unsigned tile_idx [MAX_EXISTING];
  logic [2:0]  tile_cls [MAX_EXISTING];
  int unsigned tile_cnt = 0;
  logic [6:0]  reg_width = 7'd64;
  logic [6:0]  reg_height = 7'd64;
  logic [3:0]  reg_classes = 4'd8;

  outcome_t    pending_q [$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;
  bit          tx_burst = 0;
  bit          rx_burst = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_stall = 0;

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned eff_width();
    if (reg_width < 1) return 1;
    if (reg_width > 64) return 64;
    return reg_width;
  endfunction

  function automatic int unsigned cells_used();
    int unsigned h;
    h = reg_height;
    if (h < 1) h = 1;
    if (h > 64) h = 64;
    return eff_width() * h;
  endfunction

  // floor(sqrt(v)), digit by digit
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned grid_dist(int unsigned a, int unsigned b, int unsigned w);
    longint unsigned dr, dc;
    dr = (a / w > b / w) ? a / w - b / w : b / w - a / w;
    dc = (a % w > b % w) ? a % w - b % w : b % w - a % w;
    return int_root((dr * dr + dc * dc) << 16);
  endfunction

  function automatic logic [39:0] predict_total();
    longint unsigned acc;
    int unsigned w, n_used, n_cls;
    int unsigned members [$];
    acc = 0;
    w = eff_width();
    n_used = cells_used();
    n_cls = (reg_classes > MAX_CLASSES) ? MAX_CLASSES : reg_classes;
    for (int unsigned h = 0; h < n_cls; h++) begin
      members.delete();
      for (int unsigned i = 0; i < n_used; i++)
        if (plan_q[i] == h) members.insert(members.size(), i);
      if (members.size() == 0) continue;
      for (int i = 0; i + 1 < members.size(); i++)
        for (int j = i + 1; j < members.size(); j++)
          acc += grid_dist(members[i], members[j], w);
      for (int unsigned t = 0; t < tile_cnt; t++) begin
        if (tile_cls[t] != h) continue;
        foreach (members[j]) acc += grid_dist(tile_idx[t], members[j], w);
      end
      if (acc > 40'hFF_FFFF_FFFF) acc = 40'hFF_FFFF_FFFF;
    end
    return acc[39:0];
  endfunction

  // Update predictor state for one accepted command and give its expected result
  function automatic outcome_t apply_cmd(cmd_e c, int unsigned idx, logic [3:0] code);
    outcome_t o;
    o.status = STAT_OK;
    o.total = '0;
    case (c)
      CMD_LOAD: begin
        if (idx >= cells_used()) o.status = STAT_RANGE;
        else begin
          plan_q[idx] = code[3] ? 4'hF : code;
          plan_set[idx] = 1;
        end
      end
      CMD_ADD: begin
        if (idx >= cells_used()) o.status = STAT_RANGE;
        else if (tile_cnt >= MAX_EXISTING) o.status = STAT_FULL;
        else if (!code[3]) begin
          tile_idx[tile_cnt] = idx;
          tile_cls[tile_cnt] = code[2:0];
          tile_cnt++;
        end
      end
      CMD_COMPUTE: o.total = predict_total();
      default: tile_cnt = 0;
    endcase
    return o;
  endfunction

  // Result checker and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    int unsigned n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result transaction: %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (m_axis_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[41:2] !== want.total) begin
            $error("total_distance: expected %0d, got %0d", want.total, m_axis_tdata[41:2]);
            fail_cnt++;
          end
        end
        n = rx_burst ? 0 : $urandom_range(0, 12);
        rx_stall = n;
      end
      if (rx_hold_req != 0) begin
        rx_hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Send one command; valid stays high when the next one follows at once
  task automatic send_cmd(cmd_e c, int unsigned idx, logic [3:0] code);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, code, idx[11:0], c};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.insert(pending_q.size(), apply_cmd(c, idx, code));
    sent_cnt++;
  endtask

  // Stop sending and wait until every result is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [6:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= r;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_WIDTH:  reg_width = val;
      REG_HEIGHT: reg_height = val;
      default:    reg_classes = val[3:0];
    endcase
  endtask

  task automatic set_grid(logic [6:0] w, logic [6:0] h, logic [6:0] ncls);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_CLASS, ncls);
  endtask

  // Load every cell in use that was never written; sparse keeps most cells classless
  task automatic fill_plan(bit sparse);
    logic [3:0] code;
    for (int unsigned i = 0; i < cells_used(); i++) begin
      if (plan_set[i]) continue;
      if (sparse) code = ($urandom_range(0, 63) == 0) ? 4'($urandom_range(0, 7)) : 4'hF;
      else code = 4'($urandom_range(0, 15));
      send_cmd(CMD_LOAD, i, code);
    end
  endtask

  task automatic compute_total();
    fill_plan(cells_used() > 256);
    send_cmd(CMD_COMPUTE, $urandom_range(0, 4095), 4'($urandom));
  endtask

  // Hand-picked cases on a 4x4 grid
  task automatic test_directed();
    set_grid(7'd4, 7'd4, 7'd4);
    for (int unsigned i = 0; i < 16; i += 5) send_cmd(CMD_LOAD, i, 4'd3);
    send_cmd(CMD_LOAD, 16, 4'd1);       // index past grid on load
    send_cmd(CMD_ADD, 16, 4'd3);        // index past grid on add
    send_cmd(CMD_ADD, 4095, 4'd7);
    send_cmd(CMD_ADD, 0, 4'hF);         // classless tile, not stored
    send_cmd(CMD_ADD, 3, 4'd3);
    send_cmd(CMD_ADD, 2, 4'd2);         // class without plan cells
    send_cmd(CMD_LOAD, 1, 4'd7);        // class at or above class count
    send_cmd(CMD_LOAD, 2, 4'b1000);
    compute_total();
    send_cmd(CMD_CLEAR, 4095, 4'hF);
    compute_total();
    send_cmd(CMD_ADD, 15, 4'd0);
    send_cmd(CMD_ADD, 12, 4'd3);
    compute_total();
  endtask

  // Out-of-range register values and grid shape change after tiles were added
  task automatic test_register_limits();
    set_grid(7'd0, 7'd127, 7'd15);      // width clamps to 1, height to 64, classes to 8
    send_cmd(CMD_ADD, 63, 4'd1);
    send_cmd(CMD_LOAD, 64, 4'd1);
    compute_total();
    set_grid(7'd127, 7'd1, 7'd0);       // no class takes part
    compute_total();
    write_reg(REG_CLASS, 7'd1);
    compute_total();
    set_grid(7'd8, 7'd8, 7'd8);
    compute_total();
    send_cmd(CMD_CLEAR, 0, 4'd0);
  endtask

  // Fill the tile list past its capacity
  task automatic test_list_full();
    set_grid(7'd8, 7'd8, 7'd2);
    tx_burst = 1;
    for (int unsigned i = 0; i < MAX_EXISTING + 3; i++)
      send_cmd(CMD_ADD, $urandom_range(0, cells_used() - 1), 4'($urandom_range(0, 7)));
    tx_burst = 0;
    compute_total();
    send_cmd(CMD_CLEAR, 0, 4'd0);
    compute_total();
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits for all
  task automatic test_backpressure();
    set_grid(7'd8, 7'd8, 7'd8);
    rx_hold_req = 400;
    tx_burst = 1;
    for (int i = 0; i < 20; i++) send_cmd(CMD_LOAD, $urandom_range(0, 63), 4'($urandom));
    tx_burst = 0;
    wait_idle();
    compute_total();
  endtask

  // Random sequences of loads, adds, clears and computes on varied grids
  task automatic test_random();
    int unsigned pick, n_ops, sel;
    logic [6:0] w, h;
    while (sent_cnt < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        w = 7'd64; h = 7'($urandom_range(1, 2));
      end else if (sel == 1) begin
        w = 7'($urandom_range(1, 2)); h = 7'd64;
      end else begin
        w = 7'($urandom_range(1, 8)); h = 7'($urandom_range(1, 8));
      end
      set_grid(w, h, ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 15)) : 7'd8);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n_ops = $urandom_range(10, 40);
      for (int unsigned k = 0; k < n_ops; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          send_cmd(CMD_LOAD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                   : $urandom_range(0, cells_used() - 1), 4'($urandom));
        else if (pick < 70)
          send_cmd(CMD_ADD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                   : $urandom_range(0, cells_used() - 1), 4'($urandom));
        else if (pick < 78)
          send_cmd(CMD_CLEAR, $urandom_range(0, 4095), 4'($urandom));
        else
          compute_total();
      end
      compute_total();
    end
    tx_burst = 0;
    rx_burst = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_limits();
    test_list_full();
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cpds_pkg.sv
rtl/cpds_ram.sv
rtl/cpds_sqrt.sv
rtl/class_pairwise_distance_sum.sv
test/testbench.sv
